// ===== hdl/id_open_bitmap_table_core_assert.svh =====
// Assertion macros for the open ID table.
// Used by the table's top level, which provides clk_i and rst_ni.
`ifndef ID_OPEN_BITMAP_TABLE_CORE_ASSERT_SVH
`define ID_OPEN_BITMAP_TABLE_CORE_ASSERT_SVH

// Checks a property on every rising clock edge while out of reset.
`define IDOB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that the antecedent implies the consequent in the same cycle.
`define IDOB_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/idob_pkg.sv =====
// Shared types and constants of the open ID table.
// No dependencies; used by the table's top level, not by the bitmap memory.
package idob_pkg;

  localparam int ID_W          = 16;
  localparam int CNT_W         = 11;
  localparam int ID_COUNT_DEF  = 1024;
  localparam int WORD_BITS_DEF = 32;

  localparam logic [CNT_W-1:0] MAX_OPEN_RST = 11'd1024;

  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_ALREADY_OPEN = 2'd1,
    ST_LIMIT        = 2'd2,
    ST_RANGE        = 2'd3
  } status_e;

  typedef struct packed {
    opcode_e         opcode;
    logic [ID_W-1:0] id;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic             is_open;
    logic [CNT_W-1:0] open_count;
  } rsp_t;

endpackage

// ===== hdl/id_open_bitmap_table_core.sv =====
// Top level of the open ID table: request sequencer, counters and bitmap control.
// Depends on idob_pkg, idob_bitmap_ram and id_open_bitmap_table_core_assert.svh.
//
// A request is accepted, its bitmap word is read, and then it executes and its response is
// loaded into the output register. The table starts in counter mode, where IDs 0 to
// open_count-1 are open. An open that skips ahead or a close below the top switches it to
// bitmap mode once, which fills all ceil(ID_COUNT / WORD_BITS) bitmap words one per cycle
// and then rereads the word before that request executes. A clear returns the table to
// counter mode. A new request is accepted while the previous response is still stalled;
// the next request then waits in its execute cycle until the output register frees. The
// memory's single write port paces the fill.
`include "id_open_bitmap_table_core_assert.svh"

module id_open_bitmap_table_core import idob_pkg::*; #(
  parameter int ID_COUNT  = ID_COUNT_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             req_valid_i,
  output logic             req_stall_o,
  input  req_t             req_i,
  output logic             rsp_valid_o,
  input  logic             rsp_stall_i,
  output rsp_t             rsp_o
);

  localparam int NWORDS = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BW     = $clog2(WORD_BITS);
  localparam int XW     = ID_W + 1;
  localparam int SH     = ID_W + BW;
  localparam int PW     = 2 * ID_W + 2;
  localparam logic [PW-1:0] RECIP =
    PW'(((64'd1 << SH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));
  localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);
  localparam logic [XW-1:0] ID_LIMIT  = XW'(ID_COUNT);
  localparam logic [XW-1:0] WORD_STEP = XW'(WORD_BITS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EXEC = 4'b0100,
    S_FILL = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  opcode_e                op_q;
  logic [ID_W-1:0]        id_q;
  logic [AW-1:0]          word_q;
  logic [BW-1:0]          rem_q;
  logic                   counter_mode_q, counter_mode_d;
  logic [CNT_W-1:0]       open_total_q, open_total_d;
  logic [CNT_W-1:0]       max_open_q;
  logic [AW-1:0]          fill_idx_q;
  logic [XW-1:0]          fill_base_q;
  rsp_t                   rsp_q;
  logic                   rsp_valid_q;

  logic [PW-1:0]          quot_prod;
  logic [ID_W-1:0]        word_base;
  logic [WORD_BITS-1:0]   word_rd;
  logic [WORD_BITS-1:0]   bit_mask;
  logic                   bit_hit;
  logic [XW-1:0]          id_x;
  logic [XW-1:0]          tot_x;
  logic                   out_free;

  status_e                exe_status;
  logic                   exe_answer;
  logic                   exe_wr;
  logic [WORD_BITS-1:0]   exe_wdata;
  logic                   go_fill;

  logic [XW-1:0]          fill_end;
  logic [BW-1:0]          fill_k;
  logic [WORD_BITS-1:0]   fill_word;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [WORD_BITS-1:0]   ram_wdata;

  // The word index is the ID times a scaled reciprocal of the word width.
  assign quot_prod = PW'(req_i.id) * RECIP;
  assign word_base = ID_W'(word_q) * ID_W'(WORD_BITS);

  assign id_x     = {1'b0, id_q};
  assign tot_x    = XW'(open_total_q);
  assign bit_mask = WORD_BITS'(1) << rem_q;
  assign bit_hit  = word_rd[rem_q];
  assign out_free = !rsp_valid_q || !rsp_stall_i;

  always_comb begin
    exe_status   = ST_OK;
    exe_answer   = 1'b0;
    open_total_d = open_total_q;
    exe_wr       = 1'b0;
    exe_wdata    = word_rd;
    go_fill      = 1'b0;
    if (op_q == OP_CLEAR) begin
      open_total_d = '0;
    end else if (id_x >= ID_LIMIT) begin
      exe_status = ST_RANGE;
    end else begin
      case (op_q)
        OP_OPEN: begin
          if (open_total_q >= max_open_q) begin
            exe_status = ST_LIMIT;
          end else if (counter_mode_q && id_x < tot_x) begin
            exe_status = ST_ALREADY_OPEN;
          end else if (counter_mode_q && id_x == tot_x) begin
            open_total_d = open_total_q + CNT_W'(1);
          end else if (counter_mode_q) begin
            go_fill = 1'b1;
          end else if (bit_hit) begin
            exe_status = ST_ALREADY_OPEN;
          end else begin
            exe_wr       = 1'b1;
            exe_wdata    = word_rd | bit_mask;
            open_total_d = open_total_q + CNT_W'(1);
          end
        end
        OP_CLOSE: begin
          if (counter_mode_q && (id_x + XW'(1)) == tot_x) begin
            open_total_d = open_total_q - CNT_W'(1);
          end else if (counter_mode_q && id_x >= tot_x) begin
            open_total_d = open_total_q;
          end else if (counter_mode_q) begin
            go_fill = 1'b1;
          end else if (bit_hit) begin
            exe_wr       = 1'b1;
            exe_wdata    = word_rd & ~bit_mask;
            open_total_d = open_total_q - CNT_W'(1);
          end
        end
        OP_QUERY: begin
          exe_answer = counter_mode_q ? (id_x < tot_x) : bit_hit;
        end
        default: begin
          exe_answer = 1'b0;
        end
      endcase
    end
  end

  // In counter mode the open IDs are 0 to open_total-1, so the fill sets that many bits.
  assign fill_end = fill_base_q + WORD_STEP;
  assign fill_k   = BW'(tot_x - fill_base_q);

  always_comb begin
    if (fill_end <= tot_x) begin
      fill_word = '1;
    end else if (fill_base_q < tot_x) begin
      fill_word = ~({WORD_BITS{1'b1}} << fill_k);
    end else begin
      fill_word = '0;
    end
  end

  always_comb begin
    state_d        = state_q;
    counter_mode_d = counter_mode_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (go_fill) begin
          state_d = S_FILL;
        end else if (out_free) begin
          state_d = S_IDLE;
          if (op_q == OP_CLEAR) begin
            counter_mode_d = 1'b1;
          end
        end
      end
      S_FILL: begin
        if (fill_idx_q == LAST_WORD) begin
          state_d        = S_READ;
          counter_mode_d = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      counter_mode_q <= 1'b1;
      open_total_q   <= '0;
      max_open_q     <= MAX_OPEN_RST;
      rsp_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      counter_mode_q <= counter_mode_d;
      if (cfg_we_i) begin
        max_open_q <= cfg_wdata_i;
      end
      if (state_q == S_EXEC && !go_fill && out_free) begin
        open_total_q <= open_total_d;
        rsp_valid_q  <= 1'b1;
      end else if (!rsp_stall_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_valid_i) begin
      op_q   <= req_i.opcode;
      id_q   <= req_i.id;
      word_q <= quot_prod[SH +: AW];
    end
    if (state_q == S_READ) begin
      rem_q <= BW'(id_q - word_base);
    end
    if (state_q == S_EXEC) begin
      fill_idx_q  <= '0;
      fill_base_q <= '0;
    end else if (state_q == S_FILL) begin
      fill_idx_q  <= fill_idx_q + AW'(1);
      fill_base_q <= fill_end;
    end
    if (state_q == S_EXEC && !go_fill && out_free) begin
      rsp_q.status     <= exe_status;
      rsp_q.is_open    <= exe_answer;
      rsp_q.open_count <= open_total_d;
    end
  end

  assign ram_we    = (state_q == S_FILL) || (state_q == S_EXEC && exe_wr && out_free);
  assign ram_waddr = (state_q == S_FILL) ? fill_idx_q : word_q;
  assign ram_wdata = (state_q == S_FILL) ? fill_word : exe_wdata;

  idob_bitmap_ram #(
    .DEPTH (NWORDS),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (word_q),
    .rdata_o (word_rd)
  );

  assign req_stall_o = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  `IDOB_ASSERT_IMPLIES(a_fill_only_in_counter_mode, state_q == S_FILL, counter_mode_q, "fill outside counter mode")
  `IDOB_ASSERT(a_fill_ends_in_bitmap, state_q == S_FILL && fill_idx_q == LAST_WORD |=> !counter_mode_q && state_q == S_READ, "fill did not end in bitmap mode")
  `IDOB_ASSERT(a_exec_completes, state_q == S_EXEC && !rsp_valid_q |=> rsp_valid_q || state_q == S_FILL, "free output register not loaded")
  `IDOB_ASSERT(a_total_bounded, 32'(open_total_q) <= ID_COUNT, "open count exceeds table size")

endmodule

// ===== hdl/idob_bitmap_ram.sv =====
// Bitmap word memory of the open ID table: one write port, one registered read port.
// No package dependencies.
module idob_bitmap_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/tb_id_open_bitmap_table_core.sv =====
// Self-checking testbench for the open ID table, id_open_bitmap_table_core.
// Depends on idob_pkg and the table RTL; a scoreboard class predicts every response
// from its own copy of the table, while plain tasks drive requests and limit writes.
`timescale 1ns / 100ps

module tb_id_open_bitmap_table_core import idob_pkg::*; ();

  localparam int TBL_IDS       = ID_COUNT_DEF;
  localparam int TBL_WORD_BITS = WORD_BITS_DEF;
  localparam int TBL_WORDS     = (TBL_IDS + TBL_WORD_BITS - 1) / TBL_WORD_BITS;
  localparam int SETTLE_CYCLES = TBL_WORDS + 8;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int MAX_REPORTS   = 10;

  class idob_table_scoreboard;
    logic [TBL_WORD_BITS-1:0] open_words [TBL_WORDS];
    bit   counter_mode;
    int   top_id;
    int   total;
    int   limit;
    rsp_t awaited_rsps [$];
    int   errors;

    function new();
      limit  = MAX_OPEN_RST;
      errors = 0;
      clear_table();
    endfunction

    function void clear_table();
      foreach (open_words[w]) open_words[w] = '0;
      counter_mode = 1'b1;
      top_id       = -1;
      total        = 0;
    endfunction

    // Sets bits 0 to top_id and leaves counter mode.
    function void fill_words();
      int n;
      int base;
      n = top_id + 1;
      for (int w = 0; w < TBL_WORDS; w++) begin
        base = w * TBL_WORD_BITS;
        if (base + TBL_WORD_BITS <= n) begin
          open_words[w] = '1;
        end else if (base < n) begin
          open_words[w] = {TBL_WORD_BITS{1'b1}} >> (TBL_WORD_BITS - (n - base));
        end else begin
          open_words[w] = '0;
        end
      end
      counter_mode = 1'b0;
    endfunction

    function void set_limit(logic [CNT_W-1:0] value);
      limit = value;
    endfunction

    function rsp_t apply_request(req_t r);
      rsp_t e;
      int   id;
      e.status     = ST_OK;
      e.is_open    = 1'b0;
      e.open_count = '0;
      id = r.id;
      if (r.opcode == OP_CLEAR) begin
        clear_table();
      end else if (id >= TBL_IDS) begin
        e.status = ST_RANGE;
      end else begin
        case (r.opcode)
          OP_OPEN: begin
            if (total >= limit) begin
              e.status = ST_LIMIT;
            end else if (counter_mode && id <= top_id) begin
              e.status = ST_ALREADY_OPEN;
            end else if (counter_mode && id == top_id + 1) begin
              top_id++;
              total++;
            end else begin
              if (counter_mode) fill_words();
              if (open_words[id / TBL_WORD_BITS][id % TBL_WORD_BITS]) begin
                e.status = ST_ALREADY_OPEN;
              end else begin
                open_words[id / TBL_WORD_BITS][id % TBL_WORD_BITS] = 1'b1;
                total++;
              end
            end
          end
          OP_CLOSE: begin
            if (counter_mode && id == top_id) begin
              top_id--;
              total--;
            end else if (!(counter_mode && id > top_id)) begin
              if (counter_mode) fill_words();
              if (open_words[id / TBL_WORD_BITS][id % TBL_WORD_BITS]) begin
                open_words[id / TBL_WORD_BITS][id % TBL_WORD_BITS] = 1'b0;
                total--;
              end
            end
          end
          default: begin
            if (counter_mode) begin
              e.is_open = (id <= top_id);
            end else begin
              e.is_open = open_words[id / TBL_WORD_BITS][id % TBL_WORD_BITS];
            end
          end
        endcase
      end
      e.open_count = CNT_W'(total);
      return e;
    endfunction

    function void note_request(req_t r);
      awaited_rsps.push_back(apply_request(r));
    endfunction

    function void report_mismatch(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%t: %s", $realtime, msg);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (awaited_rsps.size() == 0) begin
        report_mismatch($sformatf("response with none pending: status %0d is_open %0d count %0d",
                                  got.status, got.is_open, got.open_count));
        return;
      end
      want = awaited_rsps.pop_front();
      if (got.status !== want.status || got.is_open !== want.is_open ||
          got.open_count !== want.open_count) begin
        report_mismatch($sformatf(
          "mismatch: expected status %0d is_open %0d count %0d, got status %0d is_open %0d count %0d",
          want.status, want.is_open, want.open_count, got.status, got.is_open, got.open_count));
      end
    endfunction

    function int awaited_count();
      return awaited_rsps.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  logic             req_valid;
  logic             req_stall;
  req_t             req_data;
  logic             rsp_valid;
  logic             rsp_stall;
  rsp_t             rsp_data;

  bit                   calm = 1'b0;
  int                   cycles = 0;
  idob_table_scoreboard sb = new();

  id_open_bitmap_table_core #(
    .ID_COUNT (TBL_IDS),
    .WORD_BITS(TBL_WORD_BITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_valid_i(req_valid),
    .req_stall_o(req_stall),
    .req_i      (req_data),
    .rsp_valid_o(rsp_valid),
    .rsp_stall_i(rsp_stall),
    .rsp_o      (rsp_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  initial begin
    int run;
    rsp_stall <= 1'b0;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      repeat (run) @(posedge clk_i);
      if (!calm) begin
        rsp_stall <= 1'b1;
        repeat (idle_len()) @(posedge clk_i);
        rsp_stall <= 1'b0;
      end
    end
  end

  function automatic req_t mk(opcode_e op, int id);
    req_t r;
    r.opcode = op;
    r.id     = 16'(id);
    return r;
  endfunction

  // Some requests follow the counter-mode pattern; the rest open, close or query other IDs, go out of range or clear.
  function automatic req_t random_request();
    req_t r;
    int   roll;
    int   reach;
    roll  = $urandom_range(0, 99);
    reach = sb.top_id + 8;
    if (reach < 63) reach = 63;
    if (reach > TBL_IDS - 1 || $urandom_range(0, 7) == 0) reach = TBL_IDS - 1;
    r = mk(OP_QUERY, $urandom_range(0, reach));
    if (roll < 35) begin
      r.opcode = OP_OPEN;
      if (sb.counter_mode && sb.top_id < TBL_IDS - 1 && roll < 28) r.id = 16'(sb.top_id + 1);
    end else if (roll < 55) begin
      r.opcode = OP_CLOSE;
      if (sb.counter_mode && sb.top_id >= 0 && roll < 48) r.id = 16'(sb.top_id);
    end else if (roll < 80) begin
      r.opcode = OP_QUERY;
    end else if (roll < 88) begin
      r.opcode = OP_OPEN;
    end else if (roll < 94) begin
      r = mk(opcode_e'(2'($urandom_range(0, 2))), $urandom_range(TBL_IDS, 16'hFFFF));
    end else if (roll < 97) begin
      r = mk(opcode_e'(2'($urandom_range(0, 3))), $urandom());
    end else begin
      r = mk(OP_CLEAR, $urandom());
    end
    return r;
  endfunction

  task automatic send_req(input req_t r);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) >= 55) gap = idle_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk_i);
    while (req_stall) @(posedge clk_i);
    sb.note_request(r);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (sb.awaited_count() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.set_limit(value);
  endtask

  task automatic run_phase(input int n, input bit quiet);
    calm = quiet;
    repeat (n) send_req(random_request());
    calm = 1'b0;
  endtask

  // Clears, then opens IDs in rising order (with some queries and top closes) until the whole table is open.
  task automatic climb_to_full();
    int roll;
    send_req(mk(OP_CLEAR, 0));
    while (sb.top_id < TBL_IDS - 1) begin
      roll = $urandom_range(0, 99);
      if (roll < 94 || sb.top_id < 0) begin
        send_req(mk(OP_OPEN, sb.top_id + 1));
      end else if (roll < 97) begin
        send_req(mk(OP_QUERY, $urandom_range(0, TBL_IDS - 1)));
      end else begin
        send_req(mk(OP_CLOSE, sb.top_id));
      end
    end
  endtask

  initial begin
    rst_ni    <= 1'b0;
    req_valid <= 1'b0;
    req_data  <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(mk(OP_QUERY, 0));
    send_req(mk(OP_CLOSE, 0));
    send_req(mk(OP_OPEN, 0));
    send_req(mk(OP_OPEN, 1));
    send_req(mk(OP_OPEN, 2));
    send_req(mk(OP_OPEN, 1));
    send_req(mk(OP_QUERY, 2));
    send_req(mk(OP_QUERY, 3));
    send_req(mk(OP_CLOSE, 2));
    send_req(mk(OP_OPEN, TBL_IDS));
    send_req(mk(OP_CLOSE, 16'hFFFF));
    send_req(mk(OP_QUERY, TBL_IDS));
    send_req(mk(OP_OPEN, 5));
    send_req(mk(OP_OPEN, 5));
    send_req(mk(OP_CLOSE, 3));
    send_req(mk(OP_CLOSE, 0));
    send_req(mk(OP_QUERY, 0));
    send_req(mk(OP_QUERY, 5));
    send_req(mk(OP_CLEAR, 16'hFFFF));
    send_req(mk(OP_OPEN, 0));
    send_req(mk(OP_OPEN, 1));
    send_req(mk(OP_OPEN, 2));
    send_req(mk(OP_OPEN, 3));
    send_req(mk(OP_CLOSE, 1));
    send_req(mk(OP_CLEAR, 0));

    write_limit(11'd0);
    run_phase(25, 1'b0);
    write_limit(11'd1);
    run_phase(30, 1'b0);
    write_limit(11'd3);
    run_phase(40, 1'b1);
    write_limit(11'd37);
    run_phase(60, 1'b0);

    write_limit(11'd1024);
    climb_to_full();
    send_req(mk(OP_OPEN, 0));
    send_req(mk(OP_OPEN, TBL_IDS));
    send_req(mk(OP_CLOSE, TBL_IDS / 2));
    send_req(mk(OP_OPEN, TBL_IDS / 2));
    send_req(mk(OP_QUERY, TBL_IDS - 1));
    run_phase(40, 1'b0);

    write_limit(11'd2047);
    send_req(mk(OP_OPEN, TBL_IDS - 1));
    run_phase(40, 1'b0);
    write_limit(11'd64);
    run_phase(50, 1'b0);
    write_limit(11'd200);
    run_phase(40, 1'b1);

    wait_drained();
    if (sb.errors == 0 && sb.awaited_count() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/idob_pkg.sv
hdl/idob_bitmap_ram.sv
hdl/id_open_bitmap_table_core.sv
tb/tb_id_open_bitmap_table_core.sv
